@@ rtl/core/pid_pkg.sv @@
// Package for the PID controller: register indexes, widths, state encoding.
// Used by the channel interfaces and the top level.
package pid_pkg;
  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int IntegBits    = 48;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE  = 3'd0,
    REG_KP    = 3'd1,
    REG_KI    = 3'd2,
    REG_KD    = 3'd3,
    REG_LIMS  = 3'd4,
    REG_DBAND = 3'd5,
    REG_SEP   = 3'd6,
    REG_BANDS = 3'd7
  } reg_idx_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_P     = 9'b000000010,
    ST_I     = 9'b000000100,
    ST_D     = 9'b000001000,
    ST_TRAP  = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_VR    = 9'b001000000,
    ST_DM    = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;
endpackage

@@ rtl/core/pid_in_if.sv @@
// Input sample channel: valid, ready, measured and setpoint.
// Depends on pid_pkg for the default data width.
interface pid_in_if #(parameter int DATA_WIDTH = pid_pkg::DataWidthDef);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] setpoint;
  modport source (output valid, measured, setpoint, input ready);
  modport sink (input valid, measured, setpoint, output ready);
endinterface

@@ rtl/core/pid_out_if.sv @@
// Result channel: valid, ready, drive_out and held.
// Depends on pid_pkg for the default data width.
interface pid_out_if #(parameter int DATA_WIDTH = pid_pkg::DataWidthDef);
  logic                       valid;
  logic                       ready;
  logic signed [DATA_WIDTH:0] drive_out;
  logic                       held;
  modport source (output valid, drive_out, held, input ready);
  modport sink (input valid, drive_out, held, output ready);
endinterface

@@ rtl/core/pid_cfg_if.sv @@
// Configuration write channel: valid, ready, register index and data.
// Depends on pid_pkg for the index and data widths.
interface pid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pid_pkg::CfgIdxW-1:0]   index;
  logic [pid_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pid_with_integral_options_top.sv @@
// Top level of the PID controller with integral options.
// Depends on pid_pkg and the pid_in_if, pid_out_if and pid_cfg_if interfaces.
//
// Usage: samples (measured, setpoint) enter on the in_ channel; one result
// (drive_out, held) leaves on the out_ channel per sample. Registers are
// written on the cfg_ channel, always ready; the user must write them only while
// the block is idle, which the block itself does not enforce.
// Sequence: a held sample is loaded into the result register from the P state
// once the output is free; a full sample steps one shared 25x41 multiplier
// through P, I, D and, as the mode bits select, trapezoid I, rate fraction and
// derivative on measurement, one product a cycle except while the divider runs;
// the variable-rate fraction comes from a restoring divider that yields one
// quotient bit a cycle. Throughput: one sample at a time; in_ready is low from
// acceptance until the result is loaded. When the receiver stalls, the result
// register holds, and the next sample runs up to its last step and waits there.
// Reset clears configuration, controller state and the result valid.
module pid_with_integral_options_top #(
  parameter int DATA_WIDTH = pid_pkg::DataWidthDef,
  parameter int FRAC_BITS  = pid_pkg::FracBitsDef
) (
  input logic clk,
  input logic rst_n,
  pid_in_if.sink   in_ch,
  pid_out_if.source out_ch,
  pid_cfg_if.sink  cfg_ch
);
  localparam int IW = pid_pkg::IntegBits;
  localparam int MW = (DATA_WIDTH + 25 - FRAC_BITS > DATA_WIDTH + 3) ?
                      DATA_WIDTH + 25 - FRAC_BITS : DATA_WIDTH + 3;
  localparam int W  = MW + 31;

  logic [4:0]  mode_r;
  logic [23:0] kp_r, ki_r, kd_r;
  logic [31:0] lims_r, bands_r;
  logic [30:0] dband_r, sep_r;

  logic signed [DATA_WIDTH:0]   perr_r, err_r;
  logic signed [DATA_WIDTH-1:0] pmeas_r, meas_r;
  logic signed [IW-1:0]         isum_r;
  logic signed [W-1:0]          ldrive_r;
  logic signed [W-1:0]          pout_r, iterm_r, dout_r, dmeas_r;
  logic                         acc_r;
  pid_pkg::state_t              st_r;
  logic [4:0]                   cnt_r;
  logic [W-1:0]                 rem_r, dvs_r;
  logic [16:0]                  q_r;
  logic                         ovalid_r, oheld_r;
  logic signed [DATA_WIDTH:0]   odrive_r;

  logic signed [W-1:0] aerr, ilim, mo, ba, bb;
  logic signed [W-1:0] mul_a, prod, shifted;
  logic signed [MW-1:0] mul_am;
  logic signed [MW+24:0] prod_n;
  logic signed [24:0]  mul_g;
  logic signed [W-1:0] t_i, t_o, at_o, isum_w, sum, drv, imax, imin;
  logic signed [DATA_WIDTH:0] e_w;
  logic [W-1:0] rem_sub;
  logic hold_hit, out_free, res_ld;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = st_r == pid_pkg::ST_IDLE;
  assign out_ch.valid = ovalid_r;
  assign out_ch.drive_out = odrive_r;
  assign out_ch.held = oheld_r;

  assign e_w  = (DATA_WIDTH+1)'(in_ch.setpoint) - (DATA_WIDTH+1)'(in_ch.measured);
  assign aerr = err_r < 0 ? -W'(err_r) : W'(err_r);
  assign mo   = W'({lims_r[15:0], FRAC_BITS'(0)});
  assign ilim = W'({lims_r[31:16], FRAC_BITS'(0)});
  assign ba   = W'({bands_r[15:0], FRAC_BITS'(0)});
  assign bb   = W'({bands_r[31:16], FRAC_BITS'(0)});
  assign imax = W'({1'b0, {(IW-1){1'b1}}});
  assign imin = -imax - W'(1);

  assign hold_hit = aerr <= W'(dband_r);
  assign out_free = !ovalid_r || out_ch.ready;
  assign res_ld   = out_free && ((st_r == pid_pkg::ST_P && hold_hit) ||
                                 st_r == pid_pkg::ST_FIN);

  always_comb begin
    mul_g = 25'(kp_r);
    mul_a = W'(err_r);
    unique case (st_r)
      pid_pkg::ST_P: begin
        mul_g = 25'(kp_r); mul_a = W'(err_r);
      end
      pid_pkg::ST_I: begin
        mul_g = 25'(ki_r); mul_a = W'(err_r);
      end
      pid_pkg::ST_D: begin
        mul_g = 25'(kd_r); mul_a = W'(err_r) - W'(perr_r);
      end
      pid_pkg::ST_TRAP: begin
        mul_g = 25'(ki_r); mul_a = (W'(err_r) + W'(perr_r)) >>> 1;
      end
      pid_pkg::ST_VR: begin
        mul_g = 25'({1'b0, q_r[16:0]}); mul_a = iterm_r;
      end
      pid_pkg::ST_DM: begin
        mul_g = 25'(kd_r); mul_a = W'(pmeas_r) - W'(meas_r);
      end
      default: begin
        mul_g = 25'(kp_r); mul_a = W'(err_r);
      end
    endcase
  end
  assign mul_am  = mul_a[MW-1:0];
  assign prod_n  = mul_am * mul_g;
  assign prod    = W'(prod_n);
  assign shifted = prod >>> (st_r == pid_pkg::ST_VR ? 16 : FRAC_BITS);

  assign rem_sub = (rem_r << 1) - dvs_r;

  always_comb begin
    isum_w = W'(isum_r);
    t_i = isum_w + iterm_r;
    t_o = pout_r + isum_w + dout_r;
    at_o = t_o < 0 ? -t_o : t_o;
    sum = t_i;
    if (mode_r[3]) begin
      if (at_o > mo && acc_r) sum = isum_w;
      if (t_i > ilim) sum = ilim;
      if (t_i < -ilim) sum = -ilim;
    end
    if (sum > imax) sum = imax;
    if (sum < imin) sum = imin;
    drv = pout_r + sum + (mode_r[4] ? dmeas_r : dout_r);
    if (drv > mo) drv = mo;
    if (drv < -mo) drv = -mo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; kp_r <= '0; ki_r <= '0; kd_r <= '0;
      lims_r <= '0; bands_r <= '0; dband_r <= '0; sep_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (pid_pkg::reg_idx_t'(cfg_ch.index))
        pid_pkg::REG_MODE:  mode_r  <= cfg_ch.data[4:0];
        pid_pkg::REG_KP:    kp_r    <= cfg_ch.data[23:0];
        pid_pkg::REG_KI:    ki_r    <= cfg_ch.data[23:0];
        pid_pkg::REG_KD:    kd_r    <= cfg_ch.data[23:0];
        pid_pkg::REG_LIMS:  lims_r  <= cfg_ch.data;
        pid_pkg::REG_DBAND: dband_r <= cfg_ch.data[30:0];
        pid_pkg::REG_SEP:   sep_r   <= cfg_ch.data[30:0];
        pid_pkg::REG_BANDS: bands_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pid_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      perr_r <= '0; pmeas_r <= '0; isum_r <= '0; ldrive_r <= '0;
    end else begin
      if (res_ld) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (st_r)
        pid_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            err_r  <= e_w;
            meas_r <= in_ch.measured;
            st_r   <= pid_pkg::ST_P;
          end
        end
        pid_pkg::ST_P: begin
          acc_r <= (err_r > 0 && isum_r > 0) || (err_r < 0 && isum_r < 0);
          if (hold_hit) begin
            if (out_free) begin
              odrive_r <= ldrive_r[DATA_WIDTH:0];
              oheld_r <= 1'b1;
              perr_r <= err_r; pmeas_r <= meas_r;
              st_r <= pid_pkg::ST_IDLE;
            end
          end else begin
            pout_r <= shifted;
            st_r <= pid_pkg::ST_I;
          end
        end
        pid_pkg::ST_I: begin
          iterm_r <= (mode_r[0] && acc_r && aerr > W'(sep_r)) ? '0 : shifted;
          st_r <= pid_pkg::ST_D;
        end
        pid_pkg::ST_D: begin
          dout_r <= shifted;
          st_r <= mode_r[1] ? pid_pkg::ST_TRAP : pid_pkg::ST_DIV;
          rem_r <= W'(ba + bb - aerr);
          dvs_r <= W'(ba);
          cnt_r <= '0;
        end
        pid_pkg::ST_TRAP: begin
          iterm_r <= shifted;
          st_r <= pid_pkg::ST_DIV;
        end
        pid_pkg::ST_DIV: begin
          if (!(mode_r[2] && acc_r && aerr > bb)) begin
            st_r <= mode_r[4] ? pid_pkg::ST_DM : pid_pkg::ST_FIN;
          end else if (ba == 0 || aerr > ba + bb) begin
            iterm_r <= '0;
            st_r <= mode_r[4] ? pid_pkg::ST_DM : pid_pkg::ST_FIN;
          end else if (cnt_r == '0) begin
            q_r <= 17'(ba + bb - aerr >= ba ? 1 : 0);
            rem_r <= (ba + bb - aerr >= ba) ? W'(ba + bb - aerr - ba) : W'(ba + bb - aerr);
            cnt_r <= cnt_r + 5'd1;
          end else begin
            if (!rem_sub[W-1]) begin
              rem_r <= rem_sub;
              q_r <= {q_r[15:0], 1'b1};
            end else begin
              rem_r <= rem_r << 1;
              q_r <= {q_r[15:0], 1'b0};
            end
            if (cnt_r == 5'(16)) st_r <= pid_pkg::ST_VR;
            cnt_r <= cnt_r + 5'd1;
          end
        end
        pid_pkg::ST_VR: begin
          iterm_r <= shifted;
          st_r <= mode_r[4] ? pid_pkg::ST_DM : pid_pkg::ST_FIN;
        end
        pid_pkg::ST_DM: begin
          dmeas_r <= shifted;
          st_r <= pid_pkg::ST_FIN;
        end
        pid_pkg::ST_FIN: begin
          if (out_free) begin
            isum_r <= sum[IW-1:0];
            ldrive_r <= drv;
            odrive_r <= drv[DATA_WIDTH:0];
            oheld_r <= 1'b0;
            perr_r <= err_r; pmeas_r <= meas_r;
            st_r <= pid_pkg::ST_IDLE;
          end
        end
        default: st_r <= pid_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

@@ tb/sv/pid_checker.sv @@
// Checker for the PID controller: watches the config, sample and result channels,
// predicts each drive/held result and compares it with the block's output.
// Depends on pid_pkg and the pid_in_if, pid_out_if and pid_cfg_if interfaces.
`timescale 1ns / 1ps
module pid_checker (
  input  logic clk,
  input  logic rst_n,
  pid_in_if  in_ch,
  pid_out_if out_ch,
  pid_cfg_if cfg_ch,
  output int   mismatches,
  output int   pending
);
  typedef struct packed {
    logic signed [32:0] drive;
    logic               held;
  } pid_result_t;

  localparam longint IntegMax = (64'sd1 <<< (pid_pkg::IntegBits - 1)) - 1;
  localparam longint IntegMin = -IntegMax - 1;

  logic [4:0]  mode_bits;
  logic [23:0] kp, ki, kd;
  logic [31:0] lims, bands;
  logic [30:0] dband, sep_thr;
  longint      prev_err, prev_meas, integ, last_drive;
  pid_result_t drive_q[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit same_sign(longint e, longint acc);
    return (e > 0 && acc > 0) || (e < 0 && acc < 0);
  endfunction

  function automatic pid_result_t pid_step(longint meas, longint sp);
    longint err, aerr, drv, max_out, ilim, band_a, band_b, pout, iterm, dout;
    longint t_i, t_o, num, frac, sum;
    pid_result_t r;
    err = sp - meas;
    aerr = absl(err);
    r.held = 1'b0;
    if (aerr <= longint'(dband)) begin
      drv = last_drive;
      r.held = 1'b1;
    end else begin
      max_out = longint'(lims[15:0]) <<< 16;
      ilim = longint'(lims[31:16]) <<< 16;
      band_a = longint'(bands[15:0]) <<< 16;
      band_b = longint'(bands[31:16]) <<< 16;
      pout = fshift(longint'(kp) * err, 16);
      iterm = fshift(longint'(ki) * err, 16);
      dout = fshift(longint'(kd) * (err - prev_err), 16);
      if (mode_bits[0] && same_sign(err, integ) && aerr > longint'(sep_thr)) iterm = 0;
      if (mode_bits[1]) iterm = fshift(longint'(ki) * fshift(err + prev_err, 1), 16);
      if (mode_bits[2] && same_sign(err, integ) && aerr > band_b) begin
        if (band_a > 0 && aerr <= band_a + band_b) begin
          num = band_a + band_b - aerr;
          frac = (num <<< 16) / band_a;
          iterm = fshift(iterm * frac, 16);
        end else begin
          iterm = 0;
        end
      end
      if (mode_bits[3]) begin
        t_i = integ + iterm;
        t_o = pout + integ + dout;
        if (absl(t_o) > max_out && same_sign(err, integ)) iterm = 0;
        if (t_i > ilim) begin
          iterm = 0;
          integ = ilim;
        end
        if (t_i < -ilim) begin
          iterm = 0;
          integ = -ilim;
        end
      end
      if (mode_bits[4]) dout = fshift(longint'(kd) * (prev_meas - meas), 16);
      sum = integ + iterm;
      if (sum > IntegMax) sum = IntegMax;
      if (sum < IntegMin) sum = IntegMin;
      integ = sum;
      drv = pout + integ + dout;
      if (drv > max_out) drv = max_out;
      if (drv < -max_out) drv = -max_out;
      last_drive = drv;
    end
    prev_err = err;
    prev_meas = meas;
    r.drive = drv[32:0];
    return r;
  endfunction

  assign pending = drive_q.size();

  always @(posedge clk) begin
    pid_result_t exp_r;
    if (!rst_n) begin
      mode_bits <= '0; kp <= '0; ki <= '0; kd <= '0;
      lims <= '0; bands <= '0; dband <= '0; sep_thr <= '0;
      prev_err = 0; prev_meas = 0; integ = 0; last_drive = 0;
      drive_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (pid_pkg::reg_idx_t'(cfg_ch.index))
          pid_pkg::REG_MODE:  mode_bits <= cfg_ch.data[4:0];
          pid_pkg::REG_KP:    kp <= cfg_ch.data[23:0];
          pid_pkg::REG_KI:    ki <= cfg_ch.data[23:0];
          pid_pkg::REG_KD:    kd <= cfg_ch.data[23:0];
          pid_pkg::REG_LIMS:  lims <= cfg_ch.data;
          pid_pkg::REG_DBAND: dband <= cfg_ch.data[30:0];
          pid_pkg::REG_SEP:   sep_thr <= cfg_ch.data[30:0];
          pid_pkg::REG_BANDS: bands <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        drive_q.push_back(pid_step(longint'(in_ch.measured), longint'(in_ch.setpoint)));
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("[%0t] unexpected result drive=%0d held=%0b",
                                        $time, out_ch.drive_out, out_ch.held);
        end else begin
          exp_r = drive_q.pop_front();
          if (exp_r.drive !== out_ch.drive_out || exp_r.held !== out_ch.held) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("[%0t] mismatch: expected drive=%0d held=%0b, got drive=%0d held=%0b",
                       $time, exp_r.drive, exp_r.held, out_ch.drive_out, out_ch.held);
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_pid_with_integral_options_top.sv @@
// Testbench top for the PID controller: drives config phases, directed and random
// samples with random idle bursts on both sides; verdict from pid_checker.
// Depends on pid_pkg, the channel interfaces, pid_checker and the block.
`timescale 1ns / 1ps
module tb_pid_with_integral_options_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches, pending;
  bit   calm, done;
  int   out_gap;

  pid_in_if  in_ch();
  pid_out_if out_ch();
  pid_cfg_if cfg_ch();

  pid_with_integral_options_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pid_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(pid_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic cfg_idle;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] meas, logic [31:0] sp);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.measured <= meas;
    in_ch.setpoint <= sp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] rand_val(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  task automatic set_all(logic [31:0] m, logic [31:0] p, logic [31:0] i, logic [31:0] d,
                         logic [31:0] lim, logic [31:0] db, logic [31:0] sp,
                         logic [31:0] bd);
    write_reg(pid_pkg::REG_MODE, m);   write_reg(pid_pkg::REG_KP, p);
    write_reg(pid_pkg::REG_KI, i);     write_reg(pid_pkg::REG_KD, d);
    write_reg(pid_pkg::REG_LIMS, lim); write_reg(pid_pkg::REG_DBAND, db);
    write_reg(pid_pkg::REG_SEP, sp);   write_reg(pid_pkg::REG_BANDS, bd);
    cfg_idle();
  endtask

  initial begin
    int kind;
    logic [31:0] meas, base;
    in_ch.valid <= 1'b0;
    in_ch.measured <= '0;
    in_ch.setpoint <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_sample(32'h0, 32'h0);
    drain();
    set_all(32'h1F, 32'h01_0000, 32'h00_8000, 32'h00_4000, 32'h0100_0100,
            32'h0000_4000, 32'h0004_0000, 32'h0002_0001);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0001_0000, 32'h0001_2000);
    send_sample(32'h0, 32'h0000_4000);
    send_sample(32'h0, 32'h0000_4001);
    send_sample(32'h0, 32'h0002_8000);
    send_sample(32'h0, 32'h0003_8000);
    send_sample(32'h0, 32'h0010_0000);
    send_sample(32'h0, 32'hFFF0_0000);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    drain();
    set_all(32'h0, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0, 32'h0000_1234);
    drain();
    write_reg(pid_pkg::REG_DBAND, 32'h0);
    cfg_idle();
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    for (int k = 0; k < 5; k++) send_sample(32'h0, 32'h7FFF_0000);
    drain();
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(pid_pkg::REG_MODE, ph < 8 ? ph * 4 + ph / 2 : $urandom_range(0, 31));
      write_reg(pid_pkg::REG_KP,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h4_0000));
      write_reg(pid_pkg::REG_KI,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h2_0000));
      write_reg(pid_pkg::REG_KD,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h2_0000));
      write_reg(pid_pkg::REG_LIMS, {16'($urandom_range(0, 64)), 16'($urandom_range(0, 200))}
                | ($urandom_range(0, 5) == 0 ? $urandom() : 32'h0));
      write_reg(pid_pkg::REG_DBAND,
                $urandom_range(0, 2) == 0 ? 32'h0 : $urandom_range(0, 32'h1_0000));
      write_reg(pid_pkg::REG_SEP, $urandom_range(0, 32'h20_0000));
      write_reg(pid_pkg::REG_BANDS, {16'($urandom_range(0, 20)), 16'($urandom_range(0, 20))});
      cfg_idle();
      base = rand_val(3);
      if (ph == 12) calm = 1'b1;
      for (int k = 0; k < 100; k++) begin
        kind = $urandom_range(0, 9);
        meas = kind < 7 ? base + rand_val(1) : rand_val(kind - 7);
        send_sample(meas, kind < 7 ? base + rand_val(1) : rand_val(kind - 7));
      end
      drain();
    end
    done = 1'b1;
  end

  initial begin
    wait (done);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
